// ===== sv/epicycle_curve_point_generator_top_macros.svh =====
// Assertion macros for the checker file.
`ifndef EPICYCLE_CURVE_POINT_GENERATOR_TOP_MACROS_SVH
`define EPICYCLE_CURVE_POINT_GENERATOR_TOP_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ECPG_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define ECPG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/ecpg_pkg.sv =====
package ecpg_pkg;

	// Geometry of the index path
	localparam int MAX_SEG   = 4096;
	localparam int REM_W     = $clog2(MAX_SEG);
	localparam int SEG_W     = 13;
	localparam int IDX_W     = 12;
	localparam int PH_W      = 16;
	localparam int ANG_W     = 16;
	localparam int POS_W     = 21;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DAT_W = 16;

	// Product width of f*f*index and the divider schedule
	localparam int PROD_W    = 2 * 8 + IDX_W;
	localparam int DIV_STEPS = PROD_W + ANG_W;
	localparam int DIV_PER   = 4;
	localparam int DIV_N     = (DIV_STEPS + DIV_PER - 1) / DIV_PER;

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_SEG_COUNT   = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_RADIUS = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS_RAT  = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FREQ_MULT   = 8'd3;

	// Sine polynomial coefficients, Q30
	localparam logic [31:0] SIN_C1 = 32'd1686629713;
	localparam logic [31:0] SIN_C3 = 32'd693598669;
	localparam logic [31:0] SIN_C5 = 32'd85569305;
	localparam logic [31:0] SIN_C7 = 32'd5026995;
	localparam logic [31:0] SIN_C9 = 32'd172271;

	localparam logic signed [24:0] POS_MAX = 25'sd1048575;
	localparam logic signed [24:0] POS_MIN = -25'sd1048576;

	// One lane of the modular divider
	typedef struct packed {
		logic [REM_W-1:0]  rem;
		logic [PROD_W-1:0] x;
		logic [ANG_W-1:0]  q;
	} div_st_t;

	// Run DIV_PER restoring steps: reduce x modulo n, then form the turn fraction
	function automatic div_st_t div_steps(input div_st_t d, input logic [SEG_W-1:0] n);
		logic [REM_W:0] t;
		logic           ge;
		div_st_t        r;
		r = d;
		for (int i = 0; i < DIV_PER; i++) begin
			t = {r.rem, r.x[PROD_W-1]};
			ge = (t >= n);
			r.rem = ge ? REM_W'(t - n) : t[REM_W-1:0];
			r.x = {r.x[PROD_W-2:0], 1'b0};
			r.q = {r.q[ANG_W-2:0], ge};
		end
		return r;
	endfunction

	// One Horner step: c - (x2 * p) >> 30
	function automatic logic [31:0] horner(input logic [30:0] x2, input logic [31:0] p,
			input logic [31:0] c);
		logic [62:0] pr;
		pr = 63'(x2) * 63'(p);
		return c - pr[61:30];
	endfunction

	// Round Q35 to Q4 and saturate
	function automatic logic signed [POS_W-1:0] sat_q4(input logic signed [55:0] v);
		logic signed [55:0] b;
		logic signed [24:0] r;
		b = v + 56'sd1073741824;
		r = b[55:31];
		if (r > POS_MAX)
			return POS_MAX[POS_W-1:0];
		else if (r < POS_MIN)
			return POS_MIN[POS_W-1:0];
		return r[POS_W-1:0];
	endfunction

endpackage

// ===== sv/ecpg_req_if.sv =====
interface ecpg_req_if import ecpg_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] vertex_index;
	logic [PH_W-1:0]  phase_turns;
	modport source(output valid, vertex_index, phase_turns, input ready);
	modport sink(input valid, vertex_index, phase_turns, output ready);
endinterface

// ===== sv/ecpg_pnt_if.sv =====
interface ecpg_pnt_if import ecpg_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [IDX_W-1:0]        point_index;
	logic signed [POS_W-1:0] x_pos;
	logic signed [POS_W-1:0] y_pos;
	logic                    index_bad;
	modport source(output valid, point_index, x_pos, y_pos, index_bad, input ready);
	modport sink(input valid, point_index, x_pos, y_pos, index_bad, output ready);
endinterface

// ===== sv/ecpg_cfg_if.sv =====
interface ecpg_cfg_if import ecpg_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== sv/epicycle_curve_point_generator_top.sv =====
// Channel | dir | payload
// req     | in  | vertex_index, phase_turns
// pnt     | out | point_index, x_pos, y_pos, index_bad
// cfg     | in  | index, data (register write, always ready)
//
// Fixed 24-stage pipeline: an item enters every cycle while the output is not stalled.
// The 44 restoring steps of the modular divider (four per stage) set the largest part of the depth.
// Reset clears valid bits and restores the register defaults.
// A stalled output freezes the whole pipeline; req.ready drops for that cycle.
module epicycle_curve_point_generator_top import ecpg_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	ecpg_req_if.sink   req,
	ecpg_pnt_if.source pnt,
	ecpg_cfg_if.sink   cfg
);

	localparam int NSTG = 24;
	localparam int S_DIV0 = 2;
	localparam int S_ANG = S_DIV0 + DIV_N;

	// Configuration registers and derived radii
	logic [SEG_W-1:0] seg_q;
	logic [15:0]      base_q;
	logic [15:0]      ratio_q;
	logic [7:0]       fmul_q;
	logic [31:0]      rm_q;
	logic [33:0]      rm2_q;
	logic [SEG_W-1:0] n_eff;
	logic [48:0]      rmm;

	// Control and item tags
	logic                en;
	logic [NSTG:1]       vld_s;
	logic [IDX_W-1:0]    idx_s [1:NSTG];
	logic                bad_s [1:NSTG];
	logic [PH_W-1:0]     ph_s [1:S_ANG];
	logic [15:0]         f2_s1;

	// Divider lanes: term 0 uses k=1, term 1 k=f, term 2 k=f*f
	div_st_t [2:0]       dv_s [0:DIV_N];

	// Sine lanes: 0..2 sine of the three angles, 3..5 cosine
	logic [5:0][14:0]        u_s14;
	logic [5:0]              neg_s [14:20];
	logic [5:0][30:0]        xq_s [15:19];
	logic [5:0][30:0]        x2_s [15:18];
	logic [5:0][31:0]        poly_s [16:20];
	logic signed [17:0]      sin_s21 [6];
	logic signed [34:0]      t1_s22 [2];
	logic signed [50:0]      t2_s22 [2];
	logic signed [52:0]      t3_s22 [2];
	logic signed [55:0]      sum_s23 [2];
	logic signed [POS_W-1:0] x_s24;
	logic signed [POS_W-1:0] y_s24;

	logic [15:0]     ang [6];
	logic [5:0][14:0] u_c;
	logic [32:0]     rr [6];
	logic [18:0]     mag [6];
	logic [16:0]     mag_c [6];

	assign n_eff = (seg_q > SEG_W'(MAX_SEG)) ? SEG_W'(MAX_SEG) : seg_q;
	assign en = !vld_s[NSTG] || pnt.ready;
	assign req.ready = en;
	assign cfg.ready = 1'b1;

	// Take register writes; ignore unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q <= 13'd1060;
			base_q <= 16'd3200;
			ratio_q <= 16'd16384;
			fmul_q <= 8'd8;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_SEG_COUNT: seg_q <= cfg.data[SEG_W-1:0];
				REG_BASE_RADIUS: base_q <= cfg.data;
				REG_RADIUS_RAT: ratio_q <= cfg.data;
				REG_FREQ_MULT: fmul_q <= cfg.data[7:0];
				default: ;
			endcase
		end
	end

	// Derive r*m and r*m*m from the registers
	assign rmm = 49'(48'(rm_q) * 48'(ratio_q)) + 49'd16384;
	always_ff @(posedge clk) begin
		rm_q <= 32'(base_q) * 32'(ratio_q);
		rm2_q <= rmm[48:15];
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NSTG-1:1], req.valid};
		end
	end

	// Advance item tags and the index products
	always_ff @(posedge clk) begin
		if (en) begin
			idx_s[1] <= req.vertex_index;
			bad_s[1] <= ({1'b0, req.vertex_index} >= n_eff);
			ph_s[1] <= req.phase_turns;
			f2_s1 <= 16'(fmul_q) * 16'(fmul_q);
			for (int k = 2; k <= NSTG; k++) begin
				idx_s[k] <= idx_s[k-1];
				bad_s[k] <= bad_s[k-1];
			end
			for (int k = 2; k <= S_ANG; k++)
				ph_s[k] <= ph_s[k-1];
			for (int j = 0; j < 3; j++) begin
				dv_s[0][j].rem <= '0;
				dv_s[0][j].q <= '0;
			end
			dv_s[0][0].x <= PROD_W'(idx_s[1]);
			dv_s[0][1].x <= PROD_W'(fmul_q) * PROD_W'(idx_s[1]);
			dv_s[0][2].x <= PROD_W'(f2_s1) * PROD_W'(idx_s[1]);
		end
	end

	// Run the divider stages
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 1; k <= DIV_N; k++)
				for (int j = 0; j < 3; j++)
					dv_s[k][j] <= div_steps(dv_s[k-1][j], n_eff);
		end
	end

	// Form the six angles and fold them to the first quadrant
	always_comb begin
		ang[0] = dv_s[DIV_N][0].q;
		ang[1] = dv_s[DIV_N][1].q + ph_s[S_ANG];
		ang[2] = dv_s[DIV_N][2].q + ph_s[S_ANG];
		for (int j = 0; j < 3; j++)
			ang[j+3] = ang[j] + 16'd16384;
		for (int j = 0; j < 6; j++)
			u_c[j] = ang[j][14] ? (15'd16384 - {1'b0, ang[j][13:0]}) : {1'b0, ang[j][13:0]};
	end

	// Round the quarter sine to Q16, clamp at one
	always_comb begin
		for (int j = 0; j < 6; j++) begin
			rr[j] = {1'b0, poly_s[20][j]} + 33'd8192;
			mag[j] = rr[j][32:14];
			mag_c[j] = (mag[j] > 19'd65536) ? 17'd65536 : mag[j][16:0];
		end
	end

	// Evaluate the sine polynomial
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 6; j++) begin
				u_s14[j] <= u_c[j];
				neg_s[14][j] <= ang[j][15];
				xq_s[15][j] <= {u_s14[j], 16'd0};
				x2_s[15][j] <= 31'((62'({u_s14[j], 16'd0}) * 62'({u_s14[j], 16'd0})) >> 30);
				poly_s[16][j] <= horner(x2_s[15][j], SIN_C9, SIN_C7);
				poly_s[17][j] <= horner(x2_s[16][j], poly_s[16][j], SIN_C5);
				poly_s[18][j] <= horner(x2_s[17][j], poly_s[17][j], SIN_C3);
				poly_s[19][j] <= horner(x2_s[18][j], poly_s[18][j], SIN_C1);
				poly_s[20][j] <= 32'((63'(poly_s[19][j]) * 63'(xq_s[19][j])) >> 30);
				sin_s21[j] <= neg_s[20][j] ? -$signed({1'b0, mag_c[j]})
					: $signed({1'b0, mag_c[j]});
			end
			for (int k = 15; k <= 20; k++)
				neg_s[k] <= neg_s[k-1];
			for (int k = 16; k <= 19; k++)
				xq_s[k] <= xq_s[k-1];
			for (int k = 16; k <= 18; k++)
				x2_s[k] <= x2_s[k-1];
		end
	end

	// Scale the terms, sum them, round and saturate, and zero the point of a bad index
	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 2; c++) begin
				t1_s22[c] <= 35'($signed({1'b0, base_q})) * 35'(sin_s21[3*c]);
				t2_s22[c] <= 51'($signed({1'b0, rm_q})) * 51'(sin_s21[3*c+1]);
				t3_s22[c] <= 53'($signed({1'b0, rm2_q})) * 53'(sin_s21[3*c+2]);
				sum_s23[c] <= (56'(t1_s22[c]) <<< 15) + 56'(t2_s22[c]) + 56'(t3_s22[c]);
			end
			x_s24 <= bad_s[23] ? '0 : sat_q4(sum_s23[0]);
			y_s24 <= bad_s[23] ? '0 : sat_q4(sum_s23[1]);
		end
	end

	assign pnt.valid = vld_s[NSTG];
	assign pnt.point_index = idx_s[NSTG];
	assign pnt.index_bad = bad_s[NSTG];
	assign pnt.x_pos = x_s24;
	assign pnt.y_pos = y_s24;

endmodule

// ===== sv/ecpg_checker.sv =====
`include "epicycle_curve_point_generator_top_macros.svh"

module ecpg_checker import ecpg_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    req_valid,
	input logic                    req_ready,
	input logic                    pnt_valid,
	input logic                    pnt_ready,
	input logic [IDX_W-1:0]        point_index,
	input logic signed [POS_W-1:0] x_pos,
	input logic signed [POS_W-1:0] y_pos,
	input logic                    index_bad
);

	// Hold a waiting point until it is taken
	`ECPG_ASSERT_NEXT(a_pnt_hold, clk, arst_n, pnt_valid && !pnt_ready, pnt_valid && $stable(point_index) && $stable(x_pos) && $stable(y_pos), "point changed while stalled")

	// Stall the input whenever the output stalls
	`ECPG_ASSERT(a_backpressure, clk, arst_n, (pnt_valid && !pnt_ready) |-> !req_ready, "input taken during output stall")

	// Drop coordinates of a bad index
	`ECPG_ASSERT(a_bad_zero, clk, arst_n, (pnt_valid && index_bad) |-> (x_pos == 0 && y_pos == 0), "bad index gave nonzero point")

	// Accept input whenever the output is free
	`ECPG_ASSERT(a_ready_free, clk, arst_n, (!pnt_valid || pnt_ready) |-> req_ready, "input blocked with free output")

endmodule

bind epicycle_curve_point_generator_top ecpg_checker u_ecpg_checker (
	.clk(clk),
	.arst_n(arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.pnt_valid(pnt.valid),
	.pnt_ready(pnt.ready),
	.point_index(pnt.point_index),
	.x_pos(pnt.x_pos),
	.y_pos(pnt.y_pos),
	.index_bad(pnt.index_bad)
);
